// ===== rtl/core/cluster_extent_lookup_table_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the extent lookup table
// Shared concurrent-assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_EXTENT_LOOKUP_TABLE_DEFINES_SVH
`define CLUSTER_EXTENT_LOOKUP_TABLE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define CELT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define CELT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/celt_pkg.sv =====
// ----------------------------------------------------------------------------
// Extent lookup table package
// Field widths, entry layout, request codes and sequencer states.
// ----------------------------------------------------------------------------
package celt_pkg;

    localparam int CLUSTER_W = 48;

    typedef logic [CLUSTER_W-1:0] cluster_t;

    // One table entry
    typedef struct packed {
        logic     gone;
        cluster_t owner;
        cluster_t length;
        cluster_t start;
    } extent_t;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Flags from the shared compare unit
    typedef struct packed {
        logic start_eq_query;
        logic start_le_query;
        logic start_gt_best;
        logic best_covers;
    } cmp_flags_t;

endpackage

// ===== rtl/core/cluster_extent_lookup_table.sv =====
// ----------------------------------------------------------------------------
// Cluster extent lookup table
// Extent map with insert, predecessor lookup and clear over a scanned memory.
// ----------------------------------------------------------------------------
// Every request yields one result. Insert and lookup read the stored entries
// one per cycle through the single read port of the entry memory and feed
// them to one compare unit. Such a request passes through the entry reads,
// the last registered read data, the check that the scan has drained, the
// table update with the result load (held while the output register is
// still full), and the return to idle; the next request is accepted only
// in idle. Clear, an insert with start zero and the unused request code skip
// the scan. The result sits in an output register, so the next request is
// taken while it waits. Entries are only read below the fill count, so the
// memory needs no clearing after reset.
`include "cluster_extent_lookup_table_defines.svh"

module cluster_extent_lookup_table
    import celt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    // cluster[47:0], cluster_count[95:48], record_number[143:96],
    // is_deleted[144], zero fill [151:145]
    input  logic [151:0] s_tdata,
    // action[1:0]
    input  logic [1:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // hit[0], found_record[48:1], found_start[96:49], found_count[144:97],
    // found_deleted[145], active[146], insert_rejected[147], zero fill [151:148]
    output logic [151:0] m_tdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t           state_reg, state_next;
    action_t          act_reg;
    extent_t          item_reg;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] idx_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             have_reg;
    extent_t          best_reg;
    logic             match_reg;
    logic [IDX_W-1:0] match_idx_reg;

    logic             m_valid_reg;
    logic             hit_reg, active_reg, rejected_reg, deleted_reg;
    cluster_t         record_reg, start_reg, count_reg;

    logic             accept;
    logic             out_free;
    logic             start_zero;
    logic             rd_en;
    extent_t          rd_entry;
    cmp_flags_t       flags;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             res_load;
    logic             hit_next, rejected_next;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign out_free   = !m_valid_reg || m_tready;
    assign start_zero = (item_reg.start == '0);
    assign rd_en      = (state_reg == ST_SCAN) && (idx_reg < used_reg);

    celt_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (item_reg),
        .rd_en    (rd_en),
        .rd_addr  (idx_reg[IDX_W-1:0]),
        .rd_entry (rd_entry)
    );

    celt_cmp u_cmp (
        .entry_start (rd_entry.start),
        .query       (item_reg.start),
        .best_start  (best_reg.start),
        .best_length (best_reg.length),
        .flags       (flags)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((action_t'(s_tuser) == ACT_INSERT && s_tdata[47:0] != '0) ||
                        action_t'(s_tuser) == ACT_LOOKUP)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!rd_en && !rd_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Finish decode: table update and result
    always_comb
    begin
        wr_en         = 1'b0;
        wr_addr       = match_idx_reg;
        used_next     = used_reg;
        res_load      = 1'b0;
        hit_next      = 1'b0;
        rejected_next = 1'b0;
        unique case (state_reg) inside
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_load = 1'b1;
                    case (act_reg)
                        ACT_INSERT:
                        begin
                            if (start_zero)
                            begin
                                rejected_next = 1'b1;
                            end
                            else if (match_reg)
                            begin
                                wr_en = 1'b1;
                            end
                            else if (used_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                rejected_next = 1'b1;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = used_reg[IDX_W-1:0];
                                used_next = used_reg + 1'b1;
                            end
                        end
                        ACT_LOOKUP:
                        begin
                            hit_next = have_reg && flags.best_covers;
                        end
                        ACT_CLEAR:
                        begin
                            used_next = '0;
                        end
                        default:
                        begin
                            // unused code: leave the table alone
                        end
                    endcase
                end
            end
            ST_IDLE, ST_SCAN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            have_reg    <= 1'b0;
            match_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            rd_vld_reg <= rd_en;
            if (accept)
            begin
                idx_reg   <= '0;
                have_reg  <= 1'b0;
                match_reg <= 1'b0;
            end
            else
            begin
                if (rd_en)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (!match_reg && flags.start_eq_query)
                    begin
                        match_reg <= 1'b1;
                    end
                    if (flags.start_le_query && (!have_reg || flags.start_gt_best))
                    begin
                        have_reg <= 1'b1;
                    end
                end
            end
            if (res_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg         <= action_t'(s_tuser);
            item_reg.start  <= s_tdata[47:0];
            item_reg.length <= s_tdata[95:48];
            item_reg.owner  <= s_tdata[143:96];
            item_reg.gone   <= s_tdata[144];
        end
        if (rd_en)
        begin
            rd_idx_reg <= idx_reg[IDX_W-1:0];
        end
        if (rd_vld_reg && !accept)
        begin
            if (!match_reg && flags.start_eq_query)
            begin
                match_idx_reg <= rd_idx_reg;
            end
            if (flags.start_le_query && (!have_reg || flags.start_gt_best))
            begin
                best_reg <= rd_entry;
            end
        end
        if (res_load)
        begin
            hit_reg      <= hit_next;
            rejected_reg <= rejected_next;
            record_reg   <= hit_next ? best_reg.owner  : '0;
            start_reg    <= hit_next ? best_reg.start  : '0;
            count_reg    <= hit_next ? best_reg.length : '0;
            deleted_reg  <= hit_next && best_reg.gone;
            active_reg   <= hit_next && !best_reg.gone;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, rejected_reg, active_reg, deleted_reg,
                       count_reg, start_reg, record_reg, hit_reg};

    `CELT_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= CNT_W'(TABLE_DEPTH),
        "fill count exceeds table depth")
    `CELT_ASSERT_NOW(a_read_in_range, rd_en, idx_reg < used_reg,
        "read issued beyond the fill count")
    `CELT_ASSERT_NOW(a_write_in_range, wr_en, {1'b0, wr_addr} < {1'b0, used_next},
        "write outside the filled region")
    `CELT_ASSERT_NEXT(a_clear_empties,
        res_load && act_reg == ACT_CLEAR, used_reg == '0,
        "clear did not empty the table")
    `CELT_ASSERT_NOW(a_active_needs_hit, m_valid_reg && active_reg, hit_reg,
        "active result without a hit")

endmodule

// ===== rtl/core/celt_table.sv =====
// ----------------------------------------------------------------------------
// Extent storage
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module celt_table
    import celt_pkg::*;
#(
    parameter int  DEPTH = 256,
    localparam int IDX_W = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  extent_t          wr_entry,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output extent_t          rd_entry
);

    extent_t mem [DEPTH];
    extent_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

// ===== rtl/core/celt_cmp.sv =====
// ----------------------------------------------------------------------------
// Extent compare unit
// Compares the entry under scan against the query and the best candidate,
// and tests whether the best candidate covers the query.
// ----------------------------------------------------------------------------
module celt_cmp
    import celt_pkg::*;
(
    input  cluster_t   entry_start,
    input  cluster_t   query,
    input  cluster_t   best_start,
    input  cluster_t   best_length,
    output cmp_flags_t flags
);

    logic [CLUSTER_W:0] best_end;

    // End is one past the last cluster; keep the carry so it cannot wrap
    assign best_end = {1'b0, best_start} + {1'b0, best_length};

    always_comb
    begin
        flags.start_eq_query = (entry_start == query);
        flags.start_le_query = (entry_start <= query);
        flags.start_gt_best  = (entry_start > best_start);
        flags.best_covers    = (best_start == query) || ({1'b0, query} < best_end);
    end

endmodule
